@@ sv/normalized_2d_convolution_assert.svh @@
// Assertion macros shared by the convolution block.
// Needs signals clk and arst_n in the scope that uses them.
`ifndef NORMALIZED_2D_CONVOLUTION_ASSERT_SVH
`define NORMALIZED_2D_CONVOLUTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define NC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NC_ASSERT_IMP(lbl, ante, cons, msg) \
	`NC_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define NC_ASSERT(lbl, prop, msg)
`define NC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ sv/nconv_pkg.sv @@
// Shared constants, types and helpers for the normalised convolution block.
// No dependencies.
`timescale 1ns / 1ps
package nconv_pkg;
	localparam int MAX_IMG_W = 64;
	localparam int MAX_IMG_H = 64;
	localparam int MAX_KSIDE = 7;
	localparam int POS_W = 6;
	localparam int IMG_SZ_W = 7;
	localparam int KSZ_W = 3;
	localparam int SMP_W = 16;
	localparam int PIX_DEPTH = MAX_IMG_W * MAX_IMG_H;
	localparam int PIX_AW = $clog2(PIX_DEPTH);
	localparam int COEF_DEPTH = MAX_KSIDE * MAX_KSIDE;
	localparam int COEF_AW = $clog2(COEF_DEPTH);
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W = 40;
	localparam int SUM_W = 22;
	localparam int RES_W = 32;
	localparam int CNT_W = 6;

	localparam logic [1:0] MODE_COEF = 2'd0;
	localparam logic [1:0] MODE_PIX = 2'd1;
	localparam logic [1:0] MODE_CALC = 2'd2;

	localparam logic [2:0] REG_IMG_W = 3'd0;
	localparam logic [2:0] REG_IMG_H = 3'd1;
	localparam logic [2:0] REG_KER_W = 3'd2;
	localparam logic [2:0] REG_KER_H = 3'd3;

	typedef struct packed {
		logic walk;
		logic div_load;
		logic div_step;
		logic emit;
	} nc_cmd_t;

	typedef struct packed {
		logic go_walk;
		logic walk_last;
		logic pipe_busy;
		logic div_done;
		logic out_free;
	} nc_sts_t;

	function automatic logic [IMG_SZ_W-1:0] clamp_size(input logic [IMG_SZ_W-1:0] v,
			input logic [IMG_SZ_W-1:0] hi);
		logic [IMG_SZ_W-1:0] r;
		if (v == '0) begin
			r = IMG_SZ_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction
endpackage

@@ sv/normalized_2d_convolution.sv @@
// Normalised 2-D convolution with zero padding. A load beat (coefficient or pixel), a spare
// beat or a compute beat outside the image goes straight to the emit state once it is taken.
// A compute beat inside the image runs one multiply-accumulate per tap on a single shared
// MAC reading the pixel and coefficient memories, waits for the pipeline to drain, runs a
// 40-step restoring divider giving one quotient bit a cycle, and then loads the output
// register. The next item is taken once the result is loaded; loading waits while the
// output register is still held.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken.
`timescale 1ns / 1ps
module normalized_2d_convolution (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pos_x[5:0], pos_y[11:6], sample[27:12], zero pad
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // filtered[31:0]
	output logic [2:0]  m_tuser,  // is_result[0], saturated[1], bad_position[2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import nconv_pkg::*;

	nc_cmd_t cmd;
	nc_sts_t sts;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire = s_tvalid && s_tready;

	nconv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nconv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.in_fire   (in_fire),
		.in_mode   (s_tuser),
		.in_px     (s_tdata[5:0]),
		.in_py     (s_tdata[11:6]),
		.in_smp    (s_tdata[27:12]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_filt  (m_tdata),
		.out_isres (m_tuser[0]),
		.out_sat   (m_tuser[1]),
		.out_bad   (m_tuser[2])
	);
endmodule

@@ sv/nconv_ctrl.sv @@
// Sequencer for the normalised convolution block: accept, tap walk, drain, divide, emit.
// Depends on nconv_pkg and the assertion header.
`timescale 1ns / 1ps
`include "normalized_2d_convolution_assert.svh"
module nconv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nconv_pkg::nc_sts_t sts,
	output nconv_pkg::nc_cmd_t cmd
);
	import nconv_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DIV, ST_EMIT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= sts.go_walk ? ST_WALK : ST_EMIT;
				ST_WALK:  if (sts.walk_last) state_q <= ST_DRAIN;
				ST_DRAIN: if (!sts.pipe_busy) state_q <= ST_DIV;
				ST_DIV:   if (sts.div_done) state_q <= ST_EMIT;
				ST_EMIT:  if (sts.out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  ;
			ST_WALK:  cmd.walk = 1'b1;
			ST_DRAIN: cmd.div_load = !sts.pipe_busy;
			ST_DIV:   cmd.div_step = !sts.div_done;
			ST_EMIT:  cmd.emit = sts.out_free;
			default:  ;
		endcase
	end

	`NC_ASSERT_IMP(a_div_after_drain, state_q == ST_DIV, !sts.pipe_busy, "taps still in flight during divide")
	`NC_ASSERT(a_walk_end, (state_q == ST_WALK && sts.walk_last) |=> (state_q == ST_DRAIN), "walk did not end")
	`NC_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "result register overwritten")
endmodule

@@ sv/nconv_dp.sv @@
// Datapath: size registers, pixel and coefficient memories, MAC, serial divider, result beat.
// Depends on nconv_pkg.
`timescale 1ns / 1ps
module nconv_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_idx,
	input  logic [nconv_pkg::IMG_SZ_W-1:0] cfg_val,
	input  logic                           in_fire,
	input  logic [1:0]                     in_mode,
	input  logic [nconv_pkg::POS_W-1:0]    in_px,
	input  logic [nconv_pkg::POS_W-1:0]    in_py,
	input  logic [nconv_pkg::SMP_W-1:0]    in_smp,
	input  nconv_pkg::nc_cmd_t             cmd,
	output nconv_pkg::nc_sts_t             sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nconv_pkg::RES_W-1:0]    out_filt,
	output logic                           out_isres,
	output logic                           out_sat,
	output logic                           out_bad
);
	import nconv_pkg::*;

	logic [IMG_SZ_W-1:0] iw_q, ih_q;
	logic [KSZ_W-1:0] kw_q, kh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= IMG_SZ_W'(MAX_IMG_W);
			ih_q <= IMG_SZ_W'(MAX_IMG_H);
			kw_q <= KSZ_W'(3);
			kh_q <= KSZ_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMG_W: iw_q <= clamp_size(cfg_val, IMG_SZ_W'(MAX_IMG_W));
				REG_IMG_H: ih_q <= clamp_size(cfg_val, IMG_SZ_W'(MAX_IMG_H));
				REG_KER_W: kw_q <= KSZ_W'(clamp_size({4'b0, cfg_val[KSZ_W-1:0]},
					IMG_SZ_W'(MAX_KSIDE)));
				REG_KER_H: kh_q <= KSZ_W'(clamp_size({4'b0, cfg_val[KSZ_W-1:0]},
					IMG_SZ_W'(MAX_KSIDE)));
				default: ;
			endcase
		end
	end

	// decode of the incoming beat
	logic in_img, in_ker, wr_pix, wr_coef;
	logic [COEF_AW-1:0] wr_caddr;
	assign in_img = ({1'b0, in_px} < iw_q) && ({1'b0, in_py} < ih_q);
	assign in_ker = (in_px < POS_W'(kw_q)) && (in_py < POS_W'(kh_q));
	assign wr_pix = in_fire && in_mode == MODE_PIX && in_img;
	assign wr_coef = in_fire && in_mode == MODE_COEF && in_ker;
	assign wr_caddr = COEF_AW'(in_py[KSZ_W-1:0] * MAX_KSIDE) + COEF_AW'(in_px[KSZ_W-1:0]);
	assign sts.go_walk = in_mode == MODE_CALC && in_img;

	logic item_res_q, item_bad_q, item_calc_q;
	logic [POS_W-1:0] px_q, py_q;
	logic [KSZ_W-1:0] kr_q, kc_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_res_q <= in_mode == MODE_CALC;
			item_calc_q <= in_mode == MODE_CALC && in_img;
			unique case (in_mode)
				MODE_COEF:           item_bad_q <= !in_ker;
				MODE_PIX, MODE_CALC: item_bad_q <= !in_img;
				default:             item_bad_q <= 1'b0;
			endcase
			px_q <= in_px;
			py_q <= in_py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (in_fire) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (cmd.walk) begin
			if (kc_q == kw_q - 1'b1) begin
				kc_q <= '0;
				kr_q <= kr_q + 1'b1;
			end else begin
				kc_q <= kc_q + 1'b1;
			end
		end
	end
	assign sts.walk_last = (kr_q == kh_q - 1'b1) && (kc_q == kw_q - 1'b1);

	// tap position in the frame
	logic signed [POS_W+1:0] ix, iy;
	logic tap_in;
	logic [PIX_AW-1:0] rd_paddr;
	logic [COEF_AW-1:0] rd_caddr;
	assign ix = $signed({2'b0, px_q}) - $signed({5'b0, kw_q >> 1}) + $signed({5'b0, kc_q});
	assign iy = $signed({2'b0, py_q}) - $signed({5'b0, kh_q >> 1}) + $signed({5'b0, kr_q});
	assign tap_in = !ix[POS_W+1] && !iy[POS_W+1]
		&& (ix[POS_W:0] < iw_q) && (iy[POS_W:0] < ih_q);
	assign rd_paddr = PIX_AW'(iy[POS_W-1:0] * MAX_IMG_W) + PIX_AW'(ix[POS_W-1:0]);
	assign rd_caddr = COEF_AW'(kr_q * MAX_KSIDE) + COEF_AW'(kc_q);

	logic [SMP_W-1:0] pix_mem [PIX_DEPTH];
	logic [SMP_W-1:0] coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0] coef_vld_q;
	logic [SMP_W-1:0] pix_s1, coef_s1;
	logic cvld_s1, valid_s1, in_s1;

	always_ff @(posedge clk) begin
		if (wr_pix) pix_mem[{in_py, in_px}] <= in_smp;
		pix_s1 <= pix_mem[rd_paddr];
	end

	always_ff @(posedge clk) begin
		if (wr_coef) coef_mem[wr_caddr] <= in_smp;
		coef_s1 <= coef_mem[rd_caddr];
		in_s1 <= tap_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			cvld_s1 <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (wr_coef) coef_vld_q[wr_caddr] <= 1'b1;
			cvld_s1 <= coef_vld_q[rd_caddr];
			valid_s1 <= cmd.walk;
		end
	end

	// stage 2: product and coefficient for the running sums
	logic signed [SMP_W-1:0] coef_use;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SMP_W-1:0] coef_s2;
	logic valid_s2;
	assign coef_use = cvld_s1 ? $signed(coef_s1) : '0;

	// keep both arms signed so the product is sign-extended
	always_ff @(posedge clk) begin
		prod_s2 <= in_s1 ? $signed(pix_s1) * coef_use : PROD_W'(0);
		coef_s2 <= coef_use;
	end

	logic signed [ACC_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q <= '0;
			sum_q <= '0;
		end else begin
			valid_s2 <= valid_s1;
			if (in_fire) begin
				acc_q <= '0;
				sum_q <= '0;
			end else if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
				sum_q <= sum_q + SUM_W'(coef_s2);
			end
		end
	end
	assign sts.pipe_busy = valid_s1 || valid_s2;

	// restoring divider on magnitudes, one quotient bit a cycle
	logic [ACC_W-1:0] dvd_q;
	logic [SUM_W-1:0] dsr_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q;
	logic [SUM_W:0] trial;
	logic [SUM_W:0] diff;
	assign trial = {rem_q, dvd_q[ACC_W-1]};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= CNT_W'(ACC_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	assign sts.div_done = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
			dsr_q <= (sum_q == '0) ? SUM_W'(256) : (sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q);
			neg_q <= acc_q[ACC_W-1] ^ sum_q[SUM_W-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!diff[SUM_W]) begin
				rem_q <= diff[SUM_W-1:0];
				dvd_q <= {dvd_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SUM_W-1:0];
				dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	logic signed [ACC_W:0] quo;
	logic hi_clip, lo_clip, valid_calc;
	logic [RES_W-1:0] quo_sat;
	assign quo = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign hi_clip = quo > $signed((ACC_W+1)'(2147483647));
	assign lo_clip = quo < -$signed((ACC_W+1)'(64'd2147483648));
	assign quo_sat = hi_clip ? {1'b0, {(RES_W-1){1'b1}}}
		: (lo_clip ? {1'b1, {(RES_W-1){1'b0}}} : quo[RES_W-1:0]);
	assign valid_calc = item_calc_q && !item_bad_q;

	// result beat
	logic oval_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.emit) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_filt <= valid_calc ? quo_sat : '0;
			out_sat <= valid_calc && (hi_clip || lo_clip);
			out_isres <= item_res_q;
			out_bad <= item_bad_q;
		end
	end

	assign out_valid = oval_q;
	assign sts.out_free = !oval_q || out_ready;
endmodule

@@ tb/tb.sv @@
// Self-checking bench for normalized_2d_convolution: loads coefficients and pixels,
// requests filtered pixels and checks every reply against a scoreboard predictor.
// Depends on nconv_pkg and the normalized_2d_convolution RTL.
`timescale 1ns / 1ps
module tb;
	import nconv_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [2:0] REG_SPARE = 3'd5;

	typedef struct packed {
		logic [31:0] filtered;
		logic        bad_position;
		logic        saturated;
		logic        is_result;
	} conv_reply_t;

	class conv_scoreboard;
		logic signed [15:0] pixels[PIX_DEPTH];
		bit                 pix_loaded[PIX_DEPTH];
		logic signed [15:0] coeffs[COEF_DEPTH];
		int                 ksum;
		int                 img_w, img_h, ker_w, ker_h;
		int                 errors;
		conv_reply_t        awaited[$];

		function new();
			foreach (pixels[i]) begin
				pixels[i] = '0;
				pix_loaded[i] = 0;
			end
			foreach (coeffs[i]) coeffs[i] = '0;
			ksum = 0;
			img_w = 64;
			img_h = 64;
			ker_w = 3;
			ker_h = 3;
			errors = 0;
		endfunction

		function int clamp_to(int v, int hi);
			return (v < 1) ? 1 : (v > hi) ? hi : v;
		endfunction

		function void resum();
			ksum = 0;
			for (int r = 0; r < ker_h; r++)
				for (int c = 0; c < ker_w; c++)
					ksum += coeffs[r * MAX_KSIDE + c];
		endfunction

		function void write_register(logic [2:0] idx, logic [6:0] v);
			case (idx)
				REG_IMG_W: img_w = clamp_to(v, MAX_IMG_W);
				REG_IMG_H: img_h = clamp_to(v, MAX_IMG_H);
				REG_KER_W: begin
					ker_w = clamp_to(v & 7, MAX_KSIDE);
					resum();
				end
				REG_KER_H: begin
					ker_h = clamp_to(v & 7, MAX_KSIDE);
					resum();
				end
				default: ;
			endcase
		endfunction

		// a compute may only touch pixels that have been loaded
		function bit window_loaded(int x, int y);
			int ix, iy;
			if (x >= img_w || y >= img_h) return 1;
			for (int r = 0; r < ker_h; r++)
				for (int c = 0; c < ker_w; c++) begin
					iy = y - ker_h / 2 + r;
					ix = x - ker_w / 2 + c;
					if (iy >= 0 && iy < img_h && ix >= 0 && ix < img_w &&
							!pix_loaded[iy * MAX_IMG_W + ix])
						return 0;
				end
			return 1;
		endfunction

		function void note_input(logic [1:0] mode, int x, int y, logic signed [15:0] smp);
			conv_reply_t rep;
			longint acc, q;
			int ix, iy, k;
			rep = '0;
			case (mode)
				MODE_COEF: begin
					if (x >= ker_w || y >= ker_h) rep.bad_position = 1;
					else begin
						k = y * MAX_KSIDE + x;
						ksum += smp - coeffs[k];
						coeffs[k] = smp;
					end
				end
				MODE_PIX: begin
					if (x >= img_w || y >= img_h) rep.bad_position = 1;
					else begin
						pixels[y * MAX_IMG_W + x] = smp;
						pix_loaded[y * MAX_IMG_W + x] = 1;
					end
				end
				MODE_CALC: begin
					rep.is_result = 1;
					if (x >= img_w || y >= img_h) rep.bad_position = 1;
					else begin
						acc = 0;
						for (int r = 0; r < ker_h; r++) begin
							iy = y - ker_h / 2 + r;
							if (iy < 0 || iy >= img_h) continue;
							for (int c = 0; c < ker_w; c++) begin
								ix = x - ker_w / 2 + c;
								if (ix < 0 || ix >= img_w) continue;
								acc += longint'(pixels[iy * MAX_IMG_W + ix]) *
									longint'(coeffs[r * MAX_KSIDE + c]);
							end
						end
						q = (ksum == 0) ? acc / 256 : acc / longint'(ksum);
						if (q > 64'sd2147483647) begin
							q = 64'sd2147483647;
							rep.saturated = 1;
						end else if (q < -64'sd2147483648) begin
							q = -64'sd2147483648;
							rep.saturated = 1;
						end
						rep.filtered = q[31:0];
					end
				end
				default: ;
			endcase
			awaited.push_back(rep);
		endfunction

		task flag_mismatch(string what, longint got, longint want);
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
			errors++;
		endtask

		task check_result(logic [31:0] data, logic [2:0] user);
			conv_reply_t want;
			if (awaited.size() == 0) begin
				flag_mismatch("unexpected beat, filtered", $signed(data), 0);
				return;
			end
			want = awaited.pop_front();
			if (data !== want.filtered)
				flag_mismatch("filtered", $signed(data), $signed(want.filtered));
			if (user[0] !== want.is_result) flag_mismatch("is_result", user[0], want.is_result);
			if (user[1] !== want.saturated) flag_mismatch("saturated", user[1], want.saturated);
			if (user[2] !== want.bad_position)
				flag_mismatch("bad_position", user[2], want.bad_position);
		endtask
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [6:0]  cfg_data;

	conv_scoreboard sb = new();
	int src_idle = 0;
	int sink_idle = 0;

	normalized_2d_convolution dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("normalized_2d_convolution test failed");
		$finish;
	end

	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= sink_idle);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

	// caller sits at a falling edge; valid stays high between back-to-back beats
	task send_beat(logic [1:0] mode, int x, int y, logic [15:0] smp);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = mode;
		s_tdata = {4'b0, smp, 6'(y), 6'(x)};
		do @(posedge clk); while (!s_tready);
		sb.note_input(mode, x, y, smp);
		@(negedge clk);
	endtask

	// a compute over unloaded pixels becomes a pixel load at that spot
	task send_compute(int x, int y);
		if (sb.window_loaded(x, y)) send_beat(MODE_CALC, x, y, 16'($urandom));
		else send_beat(MODE_PIX, x, y, 16'($urandom));
	endtask

	task drain();
		s_tvalid = 0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [6:0] v);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task set_sizes(logic [6:0] iw, logic [6:0] ih, logic [6:0] kw, logic [6:0] kh);
		write_reg(REG_IMG_W, iw);
		write_reg(REG_IMG_H, ih);
		write_reg(REG_KER_W, kw);
		write_reg(REG_KER_H, kh);
	endtask

	function logic [6:0] pick_img();
		case ($urandom_range(9))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd64;
			3: return 7'd127;
			default: return 7'($urandom_range(2, 16));
		endcase
	endfunction

	task send_random();
		int x, y, sel;
		logic [15:0] smp;
		sel = $urandom_range(99);
		if ($urandom_range(99) < 15) begin
			x = $urandom_range(63);
			y = $urandom_range(63);
		end
		if (sel < 35) begin
			if (x == 0 && y == 0 || $urandom_range(99) >= 15) begin
				x = $urandom_range(sb.ker_w - 1);
				y = $urandom_range(sb.ker_h - 1);
			end
			// small coefficients give tiny or zero sums, and tiny sums drive saturation
			smp = ($urandom_range(3) == 0) ? 16'($signed($urandom_range(8)) - 4)
				: 16'($urandom);
			send_beat(MODE_COEF, x, y, smp);
		end else begin
			if ($urandom_range(99) >= 15) begin
				x = $urandom_range(sb.img_w - 1);
				y = $urandom_range(sb.img_h - 1);
			end
			if (sel < 62) send_beat(MODE_PIX, x, y, 16'($urandom));
			else if (sel < 96) send_compute(x, y);
			else send_beat(MODE_SPARE, x, y, 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes and special cases, first at the reset sizes
		send_compute(40, 40);
		send_beat(MODE_SPARE, 63, 63, 16'hffff);
		send_beat(MODE_COEF, 0, 0, 16'h7fff);
		send_beat(MODE_COEF, 2, 2, 16'h8000);
		send_beat(MODE_COEF, 3, 0, 16'h0100);
		send_beat(MODE_COEF, 0, 3, 16'h0100);
		send_beat(MODE_PIX, 63, 63, 16'h8000);
		send_beat(MODE_PIX, 62, 63, 16'h7fff);
		send_beat(MODE_PIX, 63, 62, 16'h7fff);
		send_beat(MODE_PIX, 62, 62, 16'h8000);
		send_compute(63, 63);
		send_beat(MODE_COEF, 2, 2, 16'h8001);
		send_compute(63, 63);
		send_beat(MODE_COEF, 0, 0, 16'h0000);
		send_beat(MODE_COEF, 2, 2, 16'h0000);
		send_compute(63, 63);
		for (int y = 0; y < 16; y++)
			for (int x = 0; x < 16; x++) send_beat(MODE_PIX, x, y, 16'($urandom));
		send_beat(MODE_COEF, 1, 1, 16'h0001);
		send_compute(0, 0);
		send_compute(5, 5);
		drain();
		set_sizes(7'd8, 7'd8, 7'd0, 7'd7);
		write_reg(REG_SPARE, 7'h7f);
		send_beat(MODE_PIX, 9, 0, 16'h1234);
		send_beat(MODE_PIX, 0, 8, 16'h1234);
		send_compute(10, 3);
		send_compute(7, 7);
		drain();

		for (int prof = 0; prof < 3; prof++) begin
			src_idle = (prof == 0) ? 33 : (prof == 1) ? 85 : 0;
			sink_idle = (prof == 0) ? 85 : (prof == 1) ? 33 : 0;
			for (int ph = 0; ph < 4; ph++) begin
				if (ph == 0) set_sizes(7'd127, 7'd1, 7'd7, 7'd1);
				else if (ph == 1) set_sizes(7'd1, 7'd64, 7'd1, 7'd7);
				else set_sizes(pick_img(), pick_img(), 7'($urandom_range(7)),
					7'($urandom_range(7)));
				if (ph == 3) write_reg(3'($urandom_range(4, 7)), 7'($urandom));
				repeat (70) send_random();
				drain();
			end
		end

		s_tvalid = 0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0) $display("normalized_2d_convolution test passed");
		else $display("normalized_2d_convolution test failed");
		$finish;
	end
endmodule
